// ===== rtl/front_to_back_fragment_compositor_assert.svh =====
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst in the scope of its use.
`ifndef FRONT_TO_BACK_FRAGMENT_COMPOSITOR_ASSERT_SVH
`define FRONT_TO_BACK_FRAGMENT_COMPOSITOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FTBFC_ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ftbfc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FTBFC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ftbfc assertion failed");

`endif

// ===== rtl/ftbfc_pkg.sv =====
`timescale 1ns / 1ps

package ftbfc_pkg;

  localparam int FRAC_BITS_DEF = 15;

  localparam int CHAN_W     = 16;
  localparam int PACK_W     = 48;
  localparam int OFFS_W     = 24;
  localparam int HDEN_W     = 24;
  localparam int NUM_CHAN   = 3;
  localparam int CFG_ADDR_W = 2;

  // Interpolation sum: base*2^12 + offset*step, and its magnitude
  localparam int BASE_SHIFT = 12;
  localparam int SUM_W      = 41;
  localparam int MAG_W      = 40;
  // Divisor is hden*2^10; quotient overflows once mag >= hden*2^12
  localparam int DEN_SHIFT  = 10;
  localparam int OVF_SHIFT  = 12;

  localparam logic [HDEN_W-1:0] FLAT_HDEN = HDEN_W'(65536);
  localparam logic [HDEN_W-1:0] MIN_HDEN  = HDEN_W'(1);

  localparam logic [CFG_ADDR_W-1:0] REG_SHADE_MODE = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_BG_RED     = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_BG_GREEN   = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_BG_BLUE    = CFG_ADDR_W'(3);

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_AMUL,
    S_AADD,
    S_CHECK,
    S_BMUL,
    S_BADD,
    S_EMIT
  } state_t;

  // Red sits in the high lane, blue in the low lane
  function automatic logic signed [CHAN_W-1:0] chan_sel(input logic [PACK_W-1:0] packed_val,
                                                        input logic [1:0] ch);
    logic signed [CHAN_W-1:0] v;
    unique case (ch)
      CH_RED:   v = packed_val[3*CHAN_W-1:2*CHAN_W];
      CH_GREEN: v = packed_val[2*CHAN_W-1:CHAN_W];
      default:  v = packed_val[CHAN_W-1:0];
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/ftbfc_if.sv =====
`timescale 1ns / 1ps

interface ftbfc_frag_if;
  import ftbfc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [PACK_W-1:0]        base_color;
  logic [PACK_W-1:0]        color_step;
  logic [PACK_W-1:0]        base_opacity;
  logic [PACK_W-1:0]        opacity_step;
  logic signed [OFFS_W-1:0] step_offset;
  logic [HDEN_W-1:0]        hden;
  logic                     empty_pixel;
  logic                     last_fragment;

  modport source (output valid, base_color, color_step, base_opacity, opacity_step,
                  step_offset, hden, empty_pixel, last_fragment, input ready);
  modport sink (input valid, base_color, color_step, base_opacity, opacity_step,
                step_offset, hden, empty_pixel, last_fragment, output ready);
endinterface

interface ftbfc_pix_if;
  import ftbfc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface ftbfc_cfg_if;
  import ftbfc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CHAN_W-1:0]     data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ===== rtl/ftbfc_mul.sv =====
`timescale 1ns / 1ps

module ftbfc_mul #(
  parameter int W = 24
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

// ===== rtl/ftbfc_div.sv =====
`timescale 1ns / 1ps

module ftbfc_div #(
  parameter int FRAC_BITS = ftbfc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ftbfc_pkg::MAG_W-1:0]  mag,
  input  logic [ftbfc_pkg::HDEN_W-1:0] den,
  output logic                         done,
  output logic [FRAC_BITS+1:0]         quot
);
  import ftbfc_pkg::*;

  localparam int QW = FRAC_BITS + 2;
  localparam int NW = MAG_W + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);
  localparam logic [QW-1:0] SAT = {2'b10, {FRAC_BITS{1'b0}}};

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] rem;
  logic [NW-1:0] dsh;
  logic [QW-1:0] q;
  logic          ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring division, one quotient bit per cycle, divisor walks right
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= NW'(mag) << FRAC_BITS;
      dsh <= NW'({den, {DEN_SHIFT{1'b0}}}) << (FRAC_BITS + 1);
      q   <= '0;
      ovf <= mag >= MAG_W'({den, {OVF_SHIFT{1'b0}}});
    end else if (busy) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        q   <= {q[QW-2:0], 1'b1};
      end else begin
        q <= {q[QW-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  // Anything at or past twice one clamps the same way downstream
  assign quot = (ovf || (q > SAT)) ? SAT : q;
endmodule

// ===== rtl/front_to_back_fragment_compositor.sv =====
// The block takes a new fragment only once it is through with the last. For each channel
// it interpolates and divides the colour, then the opacity, and blends the pair in; the
// background is blended in when a last fragment leaves the pixel short of opaque. One
// divider is shared by all six values. An empty pixel emits the background alone, and
// fragments after an opaque pixel are skipped up to the last fragment of that pixel.
// Synchronous reset clears the mode, background, accumulators and the skip flag.
`timescale 1ns / 1ps

module front_to_back_fragment_compositor #(
  parameter int FRAC_BITS = ftbfc_pkg::FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  ftbfc_frag_if.sink  frag,
  ftbfc_pix_if.source pix,
  ftbfc_cfg_if.sink   cfg
);
  import ftbfc_pkg::*;

  localparam int AW  = FRAC_BITS + 1;
  localparam int QW  = FRAC_BITS + 2;
  localparam int SW  = FRAC_BITS + 3;
  localparam int MW  = (SW > OFFS_W) ? SW : OFFS_W;
  localparam int PW  = 2 * MW;
  localparam int BGW = (AW > CHAN_W) ? AW : CHAN_W;
  localparam logic [AW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [1:0] LAST_CH = CH_BLUE;

  state_t state, state_next;

  logic              shade_mode;
  logic [CHAN_W-1:0] bg [NUM_CHAN];
  logic [AW-1:0]     bgc [NUM_CHAN];

  logic [AW-1:0] acc [NUM_CHAN];
  logic [AW-1:0] total [NUM_CHAN];
  logic          pdone;
  logic          emit_pdone;

  logic [PACK_W-1:0]        fr_base_col;
  logic [PACK_W-1:0]        fr_col_step;
  logic [PACK_W-1:0]        fr_base_op;
  logic [PACK_W-1:0]        fr_op_step;
  logic signed [OFFS_W-1:0] fr_offs;
  logic [HDEN_W-1:0]        fr_hden;
  logic                     fr_empty;
  logic                     fr_last;

  logic [1:0]           ch;
  logic                 phase_op;
  logic                 neg;
  logic signed [SW-1:0] col_r;
  logic [AW-1:0]        op_r;

  logic                 out_valid;
  logic [CHAN_W-1:0]    out_r, out_g, out_b;

  logic signed [MW-1:0]     mul_a, mul_b;
  logic signed [PW-1:0]     prod;
  logic                     div_start;
  logic                     div_done;
  logic [QW-1:0]            q_sat;
  logic signed [OFFS_W-1:0] offs_eff;
  logic [HDEN_W-1:0]        den_eff;
  logic signed [SUM_W-1:0]  sum;
  logic [MAG_W-1:0]         sum_mag;
  logic [PW-1:0]            pmag;
  logic [PW-1:0]            psh;
  logic signed [SW-1:0]     s_scaled;
  logic signed [SW-1:0]     acc_sum;
  logic [AW-1:0]            acc_new;
  logic [AW:0]              bg_sum;
  logic [AW-1:0]            acc_bg_new;
  logic [AW-1:0]            remaining;
  logic signed [SW-1:0]     col_val;
  logic [AW-1:0]            op_val;
  logic                     opaque;

  ftbfc_mul #(.W(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  ftbfc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (sum_mag),
    .den   (den_eff),
    .done  (div_done),
    .quot  (q_sat)
  );

  assign cfg.ready     = 1'b1;
  assign frag.ready    = (state == S_IDLE);
  assign pix.valid     = out_valid;
  assign pix.out_red   = out_r;
  assign pix.out_green = out_g;
  assign pix.out_blue  = out_b;

  // Background above one is used as one
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      bgc[c] = (BGW'(bg[c]) > BGW'(ONE)) ? ONE : AW'(bg[c]);
    end
  end

  // Interpolation sum and its magnitude for the divider
  always_comb begin
    offs_eff = shade_mode ? fr_offs : '0;
    if (!shade_mode) begin
      den_eff = FLAT_HDEN;
    end else if (fr_hden == '0) begin
      den_eff = MIN_HDEN;
    end else begin
      den_eff = fr_hden;
    end
    sum = (SUM_W'(chan_sel(phase_op ? fr_base_op : fr_base_col, ch)) <<< BASE_SHIFT)
          + SUM_W'(prod);
    sum_mag = MAG_W'(sum[SUM_W-1] ? -sum : sum);
  end

  // Product scaling, truncated toward zero, and the saturating accumulations
  always_comb begin
    pmag     = prod[PW-1] ? PW'(-prod) : PW'(prod);
    psh      = pmag >> FRAC_BITS;
    s_scaled = prod[PW-1] ? SW'(-psh) : SW'(psh);
    acc_sum  = SW'(acc[ch]) + s_scaled;
    if (acc_sum[SW-1]) begin
      acc_new = '0;
    end else if (acc_sum[SW-2:0] > (SW-1)'(ONE)) begin
      acc_new = ONE;
    end else begin
      acc_new = AW'(acc_sum);
    end
    bg_sum     = (AW+1)'(acc[ch]) + (AW+1)'(psh);
    acc_bg_new = (bg_sum > (AW+1)'(ONE)) ? ONE : AW'(bg_sum);
  end

  // Clamp colour to plus or minus two, clip opacity to what is left of one
  always_comb begin
    remaining = ONE - total[ch];
    col_val   = neg ? -SW'(q_sat) : SW'(q_sat);
    if (neg) begin
      op_val = '0;
    end else if (q_sat > QW'(remaining)) begin
      op_val = remaining;
    end else begin
      op_val = AW'(q_sat);
    end
    opaque = (total[0] == ONE) && (total[1] == ONE) && (total[2] == ONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      S_IDLE: begin
        if (frag.valid) state_next = S_START;
      end
      S_START: begin
        if (fr_empty) begin
          state_next = S_EMIT;
        end else if (pdone) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        mul_a      = MW'(offs_eff);
        mul_b      = MW'(chan_sel(phase_op ? fr_op_step : fr_col_step, ch));
        state_next = S_LOAD;
      end
      S_LOAD: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_next = phase_op ? S_AMUL : S_MUL;
      end
      S_AMUL: begin
        mul_a      = MW'(op_r);
        mul_b      = MW'(col_r);
        state_next = S_AADD;
      end
      S_AADD: begin
        state_next = (ch == LAST_CH) ? S_CHECK : S_MUL;
      end
      S_CHECK: begin
        priority if (opaque) begin
          state_next = S_EMIT;
        end else if (fr_last) begin
          state_next = S_BMUL;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_BMUL: begin
        mul_a      = MW'(remaining);
        mul_b      = MW'(bgc[ch]);
        state_next = S_BADD;
      end
      S_BADD: begin
        state_next = (ch == LAST_CH) ? S_EMIT : S_BMUL;
      end
      S_EMIT: begin
        if (!out_valid || pix.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shade_mode <= 1'b0;
      for (int c = 0; c < NUM_CHAN; c++) begin
        bg[c]    <= '0;
        acc[c]   <= '0;
        total[c] <= '0;
      end
      pdone      <= 1'b0;
      emit_pdone <= 1'b0;
      out_valid  <= 1'b0;
      ch         <= '0;
      phase_op   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.addr)
          REG_SHADE_MODE: shade_mode <= cfg.data[0];
          REG_BG_RED:     bg[0] <= cfg.data;
          REG_BG_GREEN:   bg[1] <= cfg.data;
          REG_BG_BLUE:    bg[2] <= cfg.data;
        endcase
      end
      if (state == S_EMIT && (!out_valid || pix.ready)) begin
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_START: begin
          ch       <= CH_RED;
          phase_op <= 1'b0;
          if (fr_empty) begin
            // Drop any partial pixel and emit the background alone
            for (int c = 0; c < NUM_CHAN; c++) begin
              acc[c]   <= bgc[c];
              total[c] <= '0;
            end
            emit_pdone <= 1'b0;
          end else if (pdone && fr_last) begin
            pdone <= 1'b0;
          end
        end
        S_DIV: begin
          if (div_done && !phase_op) phase_op <= 1'b1;
        end
        S_AADD: begin
          acc[ch]   <= acc_new;
          total[ch] <= total[ch] + op_r;
          phase_op  <= 1'b0;
          ch        <= (ch == LAST_CH) ? CH_RED : ch + 2'd1;
        end
        S_CHECK: begin
          emit_pdone <= !fr_last;
        end
        S_BADD: begin
          acc[ch]    <= acc_bg_new;
          ch         <= (ch == LAST_CH) ? CH_RED : ch + 2'd1;
          emit_pdone <= 1'b0;
        end
        S_EMIT: begin
          if (!out_valid || pix.ready) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
              acc[c]   <= '0;
              total[c] <= '0;
            end
            pdone <= emit_pdone;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && frag.valid) begin
      fr_base_col <= frag.base_color;
      fr_col_step <= frag.color_step;
      fr_base_op  <= frag.base_opacity;
      fr_op_step  <= frag.opacity_step;
      fr_offs     <= frag.step_offset;
      fr_hden     <= frag.hden;
      fr_empty    <= frag.empty_pixel;
      fr_last     <= frag.last_fragment;
    end
    if (state == S_LOAD) neg <= sum[SUM_W-1];
    if (state == S_DIV && div_done) begin
      if (phase_op) begin
        op_r <= op_val;
      end else begin
        col_r <= col_val;
      end
    end
    if (state == S_EMIT && (!out_valid || pix.ready)) begin
      out_r <= CHAN_W'(acc[0]);
      out_g <= CHAN_W'(acc[1]);
      out_b <= CHAN_W'(acc[2]);
    end
  end
endmodule

// ===== rtl/ftbfc_checker.sv =====
`timescale 1ns / 1ps
`include "front_to_back_fragment_compositor_assert.svh"

module ftbfc_checker #(
  parameter int FRAC_BITS = ftbfc_pkg::FRAC_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         frag_valid,
  input logic                         frag_ready,
  input logic                         pix_valid,
  input logic                         pix_ready,
  input logic [ftbfc_pkg::CHAN_W-1:0] pix_red,
  input logic [ftbfc_pkg::CHAN_W-1:0] pix_green,
  input logic [ftbfc_pkg::CHAN_W-1:0] pix_blue
);
  import ftbfc_pkg::*;

  localparam longint unsigned ONE_VAL = longint'(1) << FRAC_BITS;
  localparam bit NARROW = (FRAC_BITS < CHAN_W);

  // A stalled pixel holds its colour
  `FTBFC_ASSERT_NEXT(a_out_hold, pix_valid && !pix_ready, pix_valid && $stable(pix_red) && $stable(pix_green) && $stable(pix_blue))

  // Each fragment keeps the block busy for at least the following cycle
  `FTBFC_ASSERT_NEXT(a_busy_after_accept, frag_valid && frag_ready, !frag_ready)

  // Composited colour never passes one
  `FTBFC_ASSERT_IMPLIES(a_out_range, pix_valid && NARROW, (pix_red <= ONE_VAL) && (pix_green <= ONE_VAL) && (pix_blue <= ONE_VAL))

  // No pixel is pending right after reset
  `FTBFC_ASSERT_IMPLIES(a_empty_after_reset, $past(rst), !pix_valid)
endmodule

bind front_to_back_fragment_compositor ftbfc_checker #(.FRAC_BITS(FRAC_BITS)) u_ftbfc_checker (
  .clk        (clk),
  .rst        (rst),
  .frag_valid (frag.valid),
  .frag_ready (frag.ready),
  .pix_valid  (pix.valid),
  .pix_ready  (pix.ready),
  .pix_red    (pix.out_red),
  .pix_green  (pix.out_green),
  .pix_blue   (pix.out_blue)
);

// ===== tb/tb_front_to_back_fragment_compositor.sv =====
`timescale 1ns / 1ps

module tb_front_to_back_fragment_compositor;
  import ftbfc_pkg::*;

  localparam int     FB              = FRAC_BITS_DEF;
  localparam longint ONE             = longint'(1) << FB;
  localparam logic [CHAN_W-1:0] Q15_ONE  = 16'h8000;  // 1.0 in Q1.15
  localparam logic [CHAN_W-1:0] Q14_ONE  = 16'h4000;  // 1.0 in Q2.14
  localparam int     SETTLE_CYCLES   = 200;
  localparam int     PHASES          = 8;
  localparam int     ITEMS_PER_PHASE = 250;
  localparam int     LONG_HOLD       = 600;
  localparam int     DRAIN_LIMIT     = 500000;
  localparam longint TIMEOUT_NS      = 64'd60_000_000;

  typedef struct packed {
    logic [PACK_W-1:0]        base_color;
    logic [PACK_W-1:0]        color_step;
    logic [PACK_W-1:0]        base_opacity;
    logic [PACK_W-1:0]        opacity_step;
    logic signed [OFFS_W-1:0] step_offset;
    logic [HDEN_W-1:0]        hden;
    logic                     empty_pixel;
    logic                     last_fragment;
  } frag_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  typedef struct {
    bit                is_cfg;
    frag_t             f;
    bit                typed;
    bit                has_pix;
    pix_t              want;
    bit                mode;
    logic [CHAN_W-1:0] bg_r;
    logic [CHAN_W-1:0] bg_g;
    logic [CHAN_W-1:0] bg_b;
  } row_t;

  logic clk;
  logic rst;

  ftbfc_frag_if frag_bus ();
  ftbfc_pix_if  pix_bus ();
  ftbfc_cfg_if  cfg_bus ();

  front_to_back_fragment_compositor dut (
    .clk  (clk),
    .rst  (rst),
    .frag (frag_bus),
    .pix  (pix_bus),
    .cfg  (cfg_bus)
  );

  // Shadow of the compositor: registers and per-pixel accumulation
  bit                gouraud_mode;
  logic [CHAN_W-1:0] bg_reg[3];
  longint            color_sum[3];
  longint            alpha_sum[3];
  bit                skipping;

  pix_t pending_pixels[$];
  row_t directed_rows[$];
  int   faults;
  bit   hold_request;
  logic hold_pix;
  logic [31:0] rx_cycle = '0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  function automatic void note_fault(input string msg);
    faults++;
    if (faults <= 10) $display("%s", msg);
  endfunction

  function automatic longint lane(input logic [PACK_W-1:0] p, input int c);
    logic [CHAN_W-1:0] v;
    v = CHAN_W'(p >> (32 - 16 * c));
    return longint'(signed'(v));
  endfunction

  // (base*2^12 + offs*step) * 2^FB / (den*2^10), truncated toward zero
  function automatic longint lerp(input longint base, input longint step, input longint offs,
                                  input longint unsigned den);
    longint s;
    longint unsigned mag;
    longint unsigned q;
    s = base * 4096 + offs * step;
    mag = (s < 0) ? longint'(-s) : s;
    if (den == 0) den = 1;
    q = (mag << FB) / (den << 10);
    return (s < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    longint p;
    longint unsigned mag;
    p = a * b;
    mag = (p < 0) ? longint'(-p) : p;
    mag = mag >> FB;
    return (p < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint bg_level(input int c);
    return clip(longint'(bg_reg[c]), 0, ONE);
  endfunction

  function automatic void clear_pixel();
    for (int c = 0; c < 3; c++) begin
      color_sum[c] = 0;
      alpha_sum[c] = 0;
    end
    skipping = 1'b0;
  endfunction

  // Advance the shadow by one fragment; returns 1 when a pixel comes out
  function automatic bit blend_fragment(input frag_t f, output pix_t px);
    longint offs;
    longint col;
    longint op;
    longint unsigned den;
    px = '0;
    if (f.empty_pixel) begin
      clear_pixel();
      px = '{CHAN_W'(bg_level(0)), CHAN_W'(bg_level(1)), CHAN_W'(bg_level(2))};
      return 1'b1;
    end
    if (skipping) begin
      if (f.last_fragment) skipping = 1'b0;
      return 1'b0;
    end
    offs = gouraud_mode ? longint'(f.step_offset) : 0;
    den  = gouraud_mode ? longint'(f.hden) : 65536;
    for (int c = 0; c < 3; c++) begin
      col = lerp(lane(f.base_color, c), lane(f.color_step, c), offs, den);
      op  = lerp(lane(f.base_opacity, c), lane(f.opacity_step, c), offs, den);
      col = clip(col, -2 * ONE, 2 * ONE);
      if (op < 0) op = 0;
      if (op + alpha_sum[c] > ONE) op = ONE - alpha_sum[c];
      color_sum[c] = clip(color_sum[c] + qmul(op, col), 0, ONE);
      alpha_sum[c] += op;
    end
    if (alpha_sum[0] >= ONE && alpha_sum[1] >= ONE && alpha_sum[2] >= ONE) begin
      px = '{CHAN_W'(color_sum[0]), CHAN_W'(color_sum[1]), CHAN_W'(color_sum[2])};
      clear_pixel();
      skipping = !f.last_fragment;
      return 1'b1;
    end
    if (f.last_fragment) begin
      for (int c = 0; c < 3; c++)
        color_sum[c] = clip(color_sum[c] + qmul(ONE - alpha_sum[c], bg_level(c)), 0, ONE);
      px = '{CHAN_W'(color_sum[0]), CHAN_W'(color_sum[1]), CHAN_W'(color_sum[2])};
      clear_pixel();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [PACK_W-1:0] rgb(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                            input logic [CHAN_W-1:0] b);
    return {r, g, b};
  endfunction

  function automatic frag_t mk_frag(input logic [PACK_W-1:0] bc, input logic [PACK_W-1:0] cs,
                                    input logic [PACK_W-1:0] bo, input logic [PACK_W-1:0] os,
                                    input logic [OFFS_W-1:0] offs, input logic [HDEN_W-1:0] hd,
                                    input bit empty, input bit last);
    frag_t f;
    f.base_color    = bc;
    f.color_step    = cs;
    f.base_opacity  = bo;
    f.opacity_step  = os;
    f.step_offset   = offs;
    f.hden          = hd;
    f.empty_pixel   = empty;
    f.last_fragment = last;
    return f;
  endfunction

  function automatic void add_frag(input frag_t f, input bit typed, input bit has_pix,
                                   input pix_t want);
    row_t r;
    r = '{default: '0};
    r.f       = f;
    r.typed   = typed;
    r.has_pix = has_pix;
    r.want    = want;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input bit mode, input logic [CHAN_W-1:0] br,
                                  input logic [CHAN_W-1:0] bgn, input logic [CHAN_W-1:0] bb);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.mode   = mode;
    r.bg_r   = br;
    r.bg_g   = bgn;
    r.bg_b   = bb;
    directed_rows.push_back(r);
  endfunction

  function automatic frag_t rand_frag(input bit g);
    frag_t f;
    int style;
    int pick;
    style = $urandom_range(0, 7);
    for (int c = 0; c < 3; c++) begin
      f.base_color[16*c +: 16] = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, 16'h4000));
      if (style < 2) f.base_opacity[16*c +: 16] = 16'($urandom_range(16'h4000, 16'h7FFF));
      else if (style == 2) f.base_opacity[16*c +: 16] = 16'($urandom);
      else f.base_opacity[16*c +: 16] = 16'($urandom_range(0, 16'h2000));
      if (g && $urandom_range(0, 7) != 0) begin
        f.color_step[16*c +: 16]   = 16'($urandom_range(0, 16'h400) - 16'h200);
        f.opacity_step[16*c +: 16] = 16'($urandom_range(0, 16'h400) - 16'h200);
      end else begin
        f.color_step[16*c +: 16]   = 16'($urandom);
        f.opacity_step[16*c +: 16] = 16'($urandom);
      end
    end
    if (g && $urandom_range(0, 7) != 0)
      f.step_offset = 24'($urandom_range(0, 16'hFFFF) - 16'h8000);
    else
      f.step_offset = 24'($urandom);
    pick = $urandom_range(0, 15);
    if (!g || pick < 3) f.hden = 24'($urandom);
    else if (pick == 3) f.hden = '0;
    else f.hden = 24'($urandom_range(24'h8000, 24'h30000));
    f.empty_pixel   = 1'b0;
    f.last_fragment = 1'b0;
    return f;
  endfunction

  task automatic send_fragment(input frag_t f, input bit typed, input bit has_pix,
                               input pix_t want);
    pix_t px;
    frag_bus.valid         <= 1'b1;
    frag_bus.base_color    <= f.base_color;
    frag_bus.color_step    <= f.color_step;
    frag_bus.base_opacity  <= f.base_opacity;
    frag_bus.opacity_step  <= f.opacity_step;
    frag_bus.step_offset   <= f.step_offset;
    frag_bus.hden          <= f.hden;
    frag_bus.empty_pixel   <= f.empty_pixel;
    frag_bus.last_fragment <= f.last_fragment;
    do @(posedge clk); while (!frag_bus.ready);
    if (typed) begin
      void'(blend_fragment(f, px));
      if (has_pix) pending_pixels.push_back(want);
    end else if (blend_fragment(f, px)) begin
      pending_pixels.push_back(px);
    end
  endtask

  task automatic pause_frag(input int n);
    if (n > 0) begin
      frag_bus.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold the input until every pixel is out; optionally let a silent fragment finish too
  task automatic drain(input bit settle);
    frag_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CHAN_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= addr;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (addr)
      REG_SHADE_MODE: gouraud_mode = data[0];
      REG_BG_RED:     bg_reg[0] = data;
      REG_BG_GREEN:   bg_reg[1] = data;
      default:        bg_reg[2] = data;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input bit mode, input logic [CHAN_W-1:0] br,
                              input logic [CHAN_W-1:0] bgn, input logic [CHAN_W-1:0] bb);
    drain(1'b1);
    // upper bits of the mode word are don't-care
    write_reg(REG_SHADE_MODE, {15'($urandom), mode});
    write_reg(REG_BG_RED, br);
    write_reg(REG_BG_GREEN, bgn);
    write_reg(REG_BG_BLUE, bb);
  endtask

  function automatic logic [CHAN_W-1:0] pick_bg();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return Q15_ONE;
      2:       return 16'hFFFF;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(0, 16'h8000));
    endcase
  endfunction

  // Long hold-off on the pixel side, counted here so the sender keeps pushing
  initial begin
    hold_pix = 1'b0;
    wait (hold_request);
    @(posedge clk);
    hold_pix <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_pix <= 1'b0;
  end

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_pix) pix_bus.ready <= 1'b0;
    else begin
      case (rx_cycle[8:7])
        2'd0:    pix_bus.ready <= 1'b1;
        2'd1:    pix_bus.ready <= 1'($urandom_range(0, 1));
        2'd2:    pix_bus.ready <= ($urandom_range(0, 3) == 0);
        default: pix_bus.ready <= (rx_cycle[5:3] != 3'd0);
      endcase
    end
  end

  always @(posedge clk) begin
    pix_t got;
    pix_t want;
    if (!rst && pix_bus.valid && pix_bus.ready) begin
      got = '{pix_bus.out_red, pix_bus.out_green, pix_bus.out_blue};
      if (pending_pixels.size() == 0) begin
        note_fault($sformatf("unexpected pixel r=%h g=%h b=%h", got.red, got.green, got.blue));
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
          note_fault($sformatf("pixel mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                               want.red, want.green, want.blue, got.red, got.green, got.blue));
      end
    end
  end

  initial begin
    frag_t f;
    row_t  r;
    int    burst;
    int    sent;
    int    kind;
    int    n;
    int    spins;
    bit    drained;
    bit    mode;
    logic [CHAN_W-1:0] br, bgn, bb;

    rst                    = 1'b1;
    frag_bus.valid         = 1'b0;
    frag_bus.base_color    = '0;
    frag_bus.color_step    = '0;
    frag_bus.base_opacity  = '0;
    frag_bus.opacity_step  = '0;
    frag_bus.step_offset   = '0;
    frag_bus.hden          = '0;
    frag_bus.empty_pixel   = 1'b0;
    frag_bus.last_fragment = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.addr           = '0;
    cfg_bus.data           = '0;
    pix_bus.ready          = 1'b0;
    faults                 = 0;
    hold_request           = 1'b0;
    gouraud_mode           = 1'b0;
    for (int c = 0; c < 3; c++) bg_reg[c] = '0;
    clear_pixel();

    // Reset state: flat mode, black background
    add_frag(mk_frag('0, '0, '0, '0, '0, '0, 1, 0), 1, 1, pix_t'{16'h0, 16'h0, 16'h0});
    add_frag(mk_frag(rgb(Q14_ONE, Q14_ONE, Q14_ONE), '1, rgb(Q14_ONE, Q14_ONE, Q14_ONE), '1,
                     24'h7FFFFF, '1, 0, 0), 1, 1, pix_t'{Q15_ONE, Q15_ONE, Q15_ONE});
    add_frag(mk_frag(rgb(16'h1000, 16'h1000, 16'h1000), '0, rgb(16'h1000, 16'h1000, 16'h1000),
                     '0, '0, '0, 0, 0), 1, 0, '0);
    add_frag(mk_frag('1, '1, '1, '1, '1, '1, 0, 1), 1, 0, '0);
    add_frag(mk_frag(rgb(16'h2000, 16'h3000, 16'h0800), '0, rgb(16'h2000, 16'h1000, 16'h3FFF),
                     '0, '0, 24'h000001, 0, 1), 0, 0, '0);
    // Background registers at and above 1.0
    add_cfg(0, 16'hFFFF, Q15_ONE, 16'h0000);
    add_frag(mk_frag('1, '1, '1, '1, '1, '1, 1, 1), 1, 1, pix_t'{Q15_ONE, Q15_ONE, 16'h0});
    add_frag(mk_frag(rgb(16'h3000, 16'h2000, 16'h1000), '0, '0, '0, '0, '0, 0, 1),
             1, 1, pix_t'{Q15_ONE, Q15_ONE, 16'h0});
    add_frag(mk_frag(rgb(16'h7FFF, 16'h7FFF, 16'h7FFF), '0, rgb(16'h8000, 16'h8000, 16'h8000),
                     '0, '0, '0, 0, 1), 1, 1, pix_t'{Q15_ONE, Q15_ONE, 16'h0});
    add_frag(mk_frag(rgb(16'h8000, 16'h8000, 16'h8000), '0, rgb(16'h2000, 16'h2000, 16'h2000),
                     '0, '0, '0, 0, 0), 0, 0, '0);
    add_frag(mk_frag(rgb(16'h2000, 16'h2000, 16'h2000), '0, rgb(16'h7FFF, 16'h7FFF, 16'h7FFF),
                     '0, '0, '0, 0, 1), 0, 0, '0);
    add_frag(mk_frag(rgb(16'h3FFF, 16'h0001, 16'h2000), '0, rgb(16'h1000, 16'h1000, 16'h1000),
                     '0, '0, '0, 0, 0), 0, 0, '0);
    add_frag(mk_frag('0, '0, '0, '0, '0, '0, 1, 0), 1, 1, pix_t'{Q15_ONE, Q15_ONE, 16'h0});
    add_frag(mk_frag(rgb(16'h1234, 16'h0800, 16'h3FFF), '0, rgb(Q14_ONE, Q14_ONE, Q14_ONE),
                     '0, '0, '0, 0, 1), 0, 0, '0);
    // Gouraud: zero and extreme denominators and offsets
    add_cfg(1, 16'h0000, Q15_ONE, 16'h1234);
    add_frag(mk_frag(rgb(16'h0100, 16'h0100, 16'h0100), '0, rgb(16'h0100, 16'h0100, 16'h0100),
                     '0, '0, 24'h000000, 0, 0), 0, 0, '0);
    add_frag(mk_frag(rgb(16'h1000, 16'h1000, 16'h1000), '0, rgb(16'h1000, 16'h1000, 16'h1000),
                     '0, '0, 24'h010000, 0, 1), 0, 0, '0);
    add_frag(mk_frag(rgb(16'h7FFF, 16'h7FFF, 16'h7FFF), rgb(16'h7FFF, 16'h7FFF, 16'h7FFF),
                     rgb(16'h7FFF, 16'h7FFF, 16'h7FFF), rgb(16'h7FFF, 16'h7FFF, 16'h7FFF),
                     24'h7FFFFF, 24'hFFFFFF, 0, 1), 0, 0, '0);
    add_frag(mk_frag(rgb(16'h8000, 16'h8000, 16'h8000), rgb(16'h8000, 16'h8000, 16'h8000),
                     rgb(16'h1000, 16'h1000, 16'h1000), rgb(16'h8000, 16'h8000, 16'h8000),
                     24'h800000, 24'h010000, 0, 1), 0, 0, '0);
    add_frag(mk_frag(rgb(16'h1000, 16'h2000, 16'h3000), rgb(16'h0010, 16'hFFF0, 16'h0100),
                     rgb(16'h1000, 16'h0800, 16'h2000), rgb(16'h0020, 16'h0010, 16'hFFE0),
                     24'h004000, 24'h018000, 0, 0), 0, 0, '0);
    add_frag(mk_frag(rgb(16'h0800, 16'h3000, 16'h1800), rgb(16'hFF00, 16'h0040, 16'h0000),
                     rgb(16'h0C00, 16'h1000, 16'h0400), rgb(16'h0000, 16'hFF80, 16'h0100),
                     24'hFFC000, 24'h00C000, 0, 1), 0, 0, '0);
    add_frag(mk_frag('0, '0, '0, '0, '0, '0, 1, 0), 1, 1, pix_t'{16'h0, Q15_ONE, 16'h1234});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.is_cfg) apply_config(r.mode, r.bg_r, r.bg_g, r.bg_b);
      else send_fragment(r.f, r.typed, r.has_pix, r.want);
    end

    for (int p = 0; p < PHASES; p++) begin
      mode = (p < 2) ? 1'(p) : 1'($urandom_range(0, 1));
      case (p)
        0:       begin br = '0;       bgn = '0;       bb = '0;       end
        1:       begin br = 16'hFFFF; bgn = 16'hFFFF; bb = 16'hFFFF; end
        2:       begin br = Q15_ONE;  bgn = Q15_ONE;  bb = Q15_ONE;  end
        default: begin br = pick_bg(); bgn = pick_bg(); bb = pick_bg(); end
      endcase
      apply_config(mode, br, bgn, bb);
      burst   = $urandom_range(1, 24);
      sent    = 0;
      drained = 1'b0;
      while (sent < ITEMS_PER_PHASE) begin
        if (p == 2 && sent >= 40) hold_request = 1'b1;
        if (!drained && sent >= ITEMS_PER_PHASE / 2) begin
          drain(1'b0);
          drained = 1'b1;
        end
        kind = $urandom_range(0, 99);
        n = (kind < 12) ? 1 : $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          f = rand_frag(gouraud_mode);
          if (kind < 6) begin
            f.empty_pixel   = 1'b1;
            f.last_fragment = 1'($urandom_range(0, 1));
          end else if (kind < 12) begin
            // noise: a stray fragment with random flags
            f.last_fragment = 1'($urandom_range(0, 1));
          end else begin
            f.last_fragment = (k == n - 1);
          end
          send_fragment(f, 1'b0, 1'b0, '0);
          sent++;
          burst--;
          if (burst == 0) begin
            pause_frag(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
            burst = $urandom_range(1, 24);
          end
        end
      end
    end

    frag_bus.valid <= 1'b0;
    spins = 0;
    while (pending_pixels.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    if (pending_pixels.size() != 0)
      note_fault($sformatf("%0d pixels never came out", pending_pixels.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (faults == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ftbfc_pkg.sv
rtl/ftbfc_if.sv
rtl/ftbfc_mul.sv
rtl/ftbfc_div.sv
rtl/front_to_back_fragment_compositor.sv
rtl/ftbfc_checker.sv
tb/tb_front_to_back_fragment_compositor.sv
